### rtl/iba_pkg.sv
// Shared types and constants of the inode block map allocator.
`default_nettype none

package iba_pkg;

   // block numbers inside the block: limit stays below 32768
   localparam int BLK_W       = 15;
   localparam int TOTAL_W     = 15;
   localparam int RESERVED_W  = 14;
   localparam int HOLDER_W    = 14;
   localparam int SLOT_W      = 7;
   localparam int BLOCK_OUT_W = 14;
   localparam int BYTES_W     = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_BLOCKS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_BLOCKS = 2'd1;

   // record positions inside one plan, in emission order
   localparam int REC_SLOTS  = 6;
   localparam int SLOT_TOP   = 0;
   localparam int SLOT_MID   = 1;
   localparam int SLOT_INNER = 2;
   localparam int SLOT_ENTRY = 3;
   localparam int SLOT_DATA  = 4;
   localparam int SLOT_DONE  = 5;

   typedef enum logic [2:0] {
      KIND_DIRECT = 3'd0,
      KIND_SINGLE = 3'd1,
      KIND_DOUBLE = 3'd2,
      KIND_TRIPLE = 3'd3,
      KIND_ENTRY  = 3'd4,
      KIND_DATA   = 3'd5,
      KIND_DONE   = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [HOLDER_W-1:0]    holder;
      logic [SLOT_W-1:0]      slot;
      logic [BLOCK_OUT_W-1:0] blk;
      logic                   oos;
   } rec_type;

   // everything one accepted word turns into
   typedef struct packed {
      rec_type [REC_SLOTS-1:0] rec;
      logic [REC_SLOTS-1:0]    mask;
      logic [BYTES_W-1:0]      bytes;
   } plan_type;

endpackage

`default_nettype wire

### rtl/iba_if.sv
// Handshake channel interfaces of the inode block map allocator.
`default_nettype none

interface iba_req_if;
   logic valid;
   logic ready;
   logic last_block;
   modport source (output valid, output last_block, input ready);
   modport sink   (input valid, input last_block, output ready);
endinterface

interface iba_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_kind;
   logic [13:0] holder_block;
   logic [6:0]  slot_index;
   logic [13:0] block_number;
   logic [23:0] byte_total;
   logic        out_of_space;
   logic        last;
   modport source (output valid, output record_kind, output holder_block, output slot_index,
                   output block_number, output byte_total, output out_of_space, output last,
                   input ready);
   modport sink   (input valid, input record_kind, input holder_block, input slot_index,
                   input block_number, input byte_total, input out_of_space, input last,
                   output ready);
endinterface

interface iba_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [14:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/iba_front.sv
// Front end: configuration registers, map state and per-word record planning.
`default_nettype none

module iba_front #(
   parameter int DIRECT_SLOTS = 10,
   parameter int SINGLE_SLOTS = 4,
   parameter int BLOCK_BYTES  = 512,
   parameter int MAX_BLOCKS   = 16384
) (
   input  logic              clock,
   input  logic              reset,
   iba_req_if.sink           req_port,
   iba_csr_if.sink           csr_port,
   output iba_pkg::plan_type plan,
   output logic              push,
   input  logic              full
);
   import iba_pkg::*;

   localparam int ENTRIES = BLOCK_BYTES / 4;
   localparam int CW      = $clog2(ENTRIES + 1);
   localparam int DW      = $clog2(DIRECT_SLOTS + 1);
   localparam int SW      = $clog2(SINGLE_SLOTS + 1);
   localparam int LIM_W   = 17;
   localparam logic [BYTES_W-1:0] BYTE_MAX = {BYTES_W{1'b1}};

   typedef enum logic [2:0] {
      LVL_DIRECT = 3'd0,
      LVL_SINGLE = 3'd1,
      LVL_DOUBLE = 3'd2,
      LVL_TRIPLE = 3'd3,
      LVL_FULL   = 3'd4
   } level_type;

   logic [TOTAL_W-1:0]    total_ff;
   logic [RESERVED_W-1:0] reserved_ff;
   logic [BLK_W-1:0]      next_free_ff, next_free_in;
   level_type             level_ff, level_in;
   logic [DW-1:0]         dc_ff, dc_in;
   logic [SW-1:0]         sc_ff, sc_in;
   logic [CW-1:0]         c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in;
   logic [BLK_W-1:0]      ob0_ff, ob0_in, ob1_ff, ob1_in, ob2_ff, ob2_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;

   level_type             lv;
   logic [CW-1:0]         c0, c1, c2, c0_mid, c1_mid;
   logic                  nt, nm, ni, err, fin;
   logic [2:0]            needs;
   logic [LIM_W-1:0]      limit;
   logic [BLK_W-1:0]      base, b_mid, b_inner, b_data, ob0_new, ob1_new, ob2_new;
   logic [BYTES_W:0]      bytes_sum;
   logic [BYTES_W-1:0]    bytes_new;

   function automatic logic need_new(logic [CW-1:0] c);
      return (c == '0) || (c >= CW'(ENTRIES));
   endfunction

   assign req_port.ready = !full;
   assign csr_port.ready = 1'b1;
   assign push           = req_port.valid && !full;
   assign fin            = req_port.last_block;

   // classify the word and plan its records
   always_comb begin
      // step to the level that can take this block
      lv = level_ff;
      c0 = c0_ff;
      c1 = c1_ff;
      c2 = c2_ff;
      if (lv == LVL_DIRECT && dc_ff >= DW'(DIRECT_SLOTS)) begin
         lv = LVL_SINGLE;
         c0 = '0; c1 = '0; c2 = '0;
      end
      if (lv == LVL_SINGLE && need_new(c0) && sc_ff >= SW'(SINGLE_SLOTS)) begin
         lv = LVL_DOUBLE;
         c0 = '0; c1 = '0; c2 = '0;
      end
      if (lv == LVL_DOUBLE && need_new(c0) && c1 >= CW'(ENTRIES)) begin
         lv = LVL_TRIPLE;
         c0 = '0; c1 = '0; c2 = '0;
      end
      if (lv == LVL_TRIPLE && need_new(c0) && need_new(c1) && c2 >= CW'(ENTRIES)) begin
         lv = LVL_FULL;
      end

      // pointer blocks this word needs
      nt = 1'b0;
      nm = 1'b0;
      ni = 1'b0;
      unique case (lv)
         LVL_SINGLE: begin
            ni = need_new(c0);
         end
         LVL_DOUBLE: begin
            ni = need_new(c0);
            nm = (c1 == '0);
         end
         LVL_TRIPLE: begin
            ni = need_new(c0);
            nm = ni && need_new(c1);
            nt = nm && (c2 == '0);
         end
         default: begin
         end
      endcase
      needs = 3'd1 + 3'(nt) + 3'(nm) + 3'(ni);

      limit = (LIM_W'(total_ff) < LIM_W'(MAX_BLOCKS)) ? LIM_W'(total_ff) : LIM_W'(MAX_BLOCKS);
      base  = (next_free_ff > BLK_W'(reserved_ff)) ? next_free_ff : BLK_W'(reserved_ff);
      err   = (lv == LVL_FULL) || (LIM_W'(base) + LIM_W'(needs) > limit);

      // block numbers in allocation order
      b_mid   = base + BLK_W'(nt);
      b_inner = b_mid + BLK_W'(nm);
      b_data  = b_inner + BLK_W'(ni);
      ob2_new = nt ? base : ob2_ff;
      ob1_new = nm ? b_mid : ob1_ff;
      ob0_new = ni ? b_inner : ob0_ff;
      c1_mid  = nm ? '0 : c1;
      c0_mid  = ni ? '0 : c0;

      bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(BLOCK_BYTES);
      bytes_new = err ? bytes_ff :
                  (bytes_sum > {1'b0, BYTE_MAX}) ? BYTE_MAX : bytes_sum[BYTES_W-1:0];

      // default: map state moves only through the level step; the byte count takes its new value
      level_in     = lv;
      c0_in        = c0;
      c1_in        = c1;
      c2_in        = c2;
      dc_in        = dc_ff;
      sc_in        = sc_ff;
      ob0_in       = ob0_ff;
      ob1_in       = ob1_ff;
      ob2_in       = ob2_ff;
      next_free_in = next_free_ff;
      bytes_in     = bytes_new;
      if (!err) begin
         next_free_in = b_data + BLK_W'(1);
         if (lv == LVL_DIRECT) begin
            dc_in = dc_ff + DW'(1);
         end else begin
            ob2_in = ob2_new;
            ob1_in = ob1_new;
            ob0_in = ob0_new;
            if (nm && lv == LVL_TRIPLE) begin
               c2_in = c2 + CW'(1);
            end
            c1_in = c1_mid;
            if (ni && lv == LVL_SINGLE) begin
               sc_in = sc_ff + SW'(1);
            end else if (ni) begin
               c1_in = c1_mid + CW'(1);
            end
            c0_in = c0_mid + CW'(1);
         end
      end

      // clear the layout after the file's final block
      if (fin) begin
         level_in = LVL_DIRECT;
         dc_in    = '0;
         sc_in    = '0;
         c0_in    = '0;
         c1_in    = '0;
         c2_in    = '0;
         ob0_in   = '0;
         ob1_in   = '0;
         ob2_in   = '0;
         bytes_in = '0;
      end

      // build the records
      plan.bytes = bytes_new;
      plan.mask  = '0;
      plan.mask[SLOT_TOP]   = nt && !err;
      plan.mask[SLOT_MID]   = nm && !err;
      plan.mask[SLOT_INNER] = ni && !err;
      plan.mask[SLOT_ENTRY] = !err;
      plan.mask[SLOT_DATA]  = 1'b1;
      plan.mask[SLOT_DONE]  = fin;

      plan.rec[SLOT_TOP] = '{kind: KIND_TRIPLE, holder: '0, slot: '0,
                             blk: BLOCK_OUT_W'(base), oos: 1'b0};

      if (lv == LVL_TRIPLE) begin
         plan.rec[SLOT_MID] = '{kind: KIND_ENTRY, holder: HOLDER_W'(ob2_new),
                                slot: SLOT_W'(c2), blk: BLOCK_OUT_W'(b_mid), oos: 1'b0};
      end else begin
         plan.rec[SLOT_MID] = '{kind: KIND_DOUBLE, holder: '0, slot: '0,
                                blk: BLOCK_OUT_W'(b_mid), oos: 1'b0};
      end

      if (lv == LVL_SINGLE) begin
         plan.rec[SLOT_INNER] = '{kind: KIND_SINGLE, holder: '0, slot: SLOT_W'(sc_ff),
                                  blk: BLOCK_OUT_W'(b_inner), oos: 1'b0};
      end else begin
         plan.rec[SLOT_INNER] = '{kind: KIND_ENTRY, holder: HOLDER_W'(ob1_new),
                                  slot: SLOT_W'(c1_mid), blk: BLOCK_OUT_W'(b_inner),
                                  oos: 1'b0};
      end

      if (lv == LVL_DIRECT) begin
         plan.rec[SLOT_ENTRY] = '{kind: KIND_DIRECT, holder: '0, slot: SLOT_W'(dc_ff),
                                  blk: BLOCK_OUT_W'(base), oos: 1'b0};
      end else begin
         plan.rec[SLOT_ENTRY] = '{kind: KIND_ENTRY, holder: HOLDER_W'(ob0_new),
                                  slot: SLOT_W'(c0_mid), blk: BLOCK_OUT_W'(b_data),
                                  oos: 1'b0};
      end

      plan.rec[SLOT_DATA] = '{kind: KIND_DATA, holder: '0, slot: '0,
                              blk: err ? '0 : BLOCK_OUT_W'(b_data), oos: err};
      plan.rec[SLOT_DONE] = '{kind: KIND_DONE, holder: '0, slot: '0, blk: '0, oos: 1'b0};
   end

   // hold configuration and map state, advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= TOTAL_W'(16384);
         reserved_ff  <= '0;
         next_free_ff <= '0;
         level_ff     <= LVL_DIRECT;
         dc_ff        <= '0;
         sc_ff        <= '0;
         c0_ff        <= '0;
         c1_ff        <= '0;
         c2_ff        <= '0;
         ob0_ff       <= '0;
         ob1_ff       <= '0;
         ob2_ff       <= '0;
         bytes_ff     <= '0;
      end else begin
         if (csr_port.valid) begin
            case (csr_port.index)
               CSR_IMAGE_BLOCKS:    total_ff    <= csr_port.data[TOTAL_W-1:0];
               CSR_RESERVED_BLOCKS: reserved_ff <= csr_port.data[RESERVED_W-1:0];
               default: begin
               end
            endcase
         end
         if (push) begin
            next_free_ff <= next_free_in;
            level_ff     <= level_in;
            dc_ff        <= dc_in;
            sc_ff        <= sc_in;
            c0_ff        <= c0_in;
            c1_ff        <= c1_in;
            c2_ff        <= c2_in;
            ob0_ff       <= ob0_in;
            ob1_ff       <= ob1_in;
            ob2_ff       <= ob2_in;
            bytes_ff     <= bytes_in;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/iba_queue.sv
// Two-entry plan queue between the front end and the record sequencer.
`default_nettype none

module iba_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iba_pkg::plan_type plan_in,
   output logic              full,
   input  logic              pop,
   output iba_pkg::plan_type head,
   output logic              nonempty
);
   import iba_pkg::*;

   plan_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign nonempty = (count_ff != 2'd0);
   assign head     = mem_ff[rd_ptr_ff];

   // store plans
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= plan_in;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/iba_back.sv
// Record sequencer: sends head plan records one per cycle while rsp_port is ready.
`default_nettype none

module iba_back (
   input  logic              clock,
   input  logic              reset,
   input  iba_pkg::plan_type head,
   input  logic              nonempty,
   output logic              pop,
   iba_rsp_if.source         rsp_port
);
   import iba_pkg::*;

   logic [REC_SLOTS-1:0] done_ff, done_in;
   logic [REC_SLOTS-1:0] remaining, cur;
   rec_type              sel;
   logic                 fire, is_last;

   // pick the lowest record not yet sent
   always_comb begin
      remaining = head.mask & ~done_ff;
      cur       = remaining & (~remaining + REC_SLOTS'(1));
      is_last   = ((remaining & ~cur) == '0);
      sel       = '0;
      for (int i = 0; i < REC_SLOTS; i++) begin
         if (cur[i]) begin
            sel = head.rec[i];
         end
      end
   end

   assign rsp_port.valid        = nonempty;
   assign rsp_port.record_kind  = sel.kind;
   assign rsp_port.holder_block = sel.holder;
   assign rsp_port.slot_index   = sel.slot;
   assign rsp_port.block_number = sel.blk;
   assign rsp_port.byte_total   = head.bytes;
   assign rsp_port.out_of_space = sel.oos;
   assign rsp_port.last         = is_last;

   assign fire = nonempty && rsp_port.ready;
   assign pop  = fire && is_last;

   // mark sent records, drop the plan after its last word
   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = '0;
      end else if (fire) begin
         done_in = done_ff | cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

### rtl/inode_block_map_allocator.sv
// Top level of the inode block map allocator.
//
// req_port takes one word per arriving file data block (last_block marks the
// file's final block). rsp_port returns the records that block causes: any
// new pointer blocks, the pointer entries written, the data placement, and a
// file-done record on the last block; last marks the final record of a word.
// csr_port writes the image size in blocks (index 0) and the reserved area
// size (index 1); it is always ready, and the user must see that it is written
// only while the block is idle; the block itself does not enforce this. The
// front end plans a word in the cycle it is accepted and can accept one word
// per cycle while its two-entry plan queue has room. The sequencer sends one
// record per cycle while rsp_port is ready; a word has two records in the
// common case, up to six at a triple-indirect boundary. A word's first record
// appears once its plan reaches the queue head. Reset clears the layout and
// next-free counter and restores the register defaults; no clearing pass follows.
// When rsp_port stalls, the current record holds; the front end keeps taking
// words until the plan queue is full, then drops req_port.ready.
`default_nettype none

module inode_block_map_allocator #(
   parameter int DIRECT_SLOTS = 10,
   parameter int SINGLE_SLOTS = 4,
   parameter int BLOCK_BYTES  = 512,
   parameter int MAX_BLOCKS   = 16384
) (
   input  logic      clock,
   input  logic      reset,
   iba_req_if.sink   req_port,
   iba_rsp_if.source rsp_port,
   iba_csr_if.sink   csr_port
);
   import iba_pkg::*;

   plan_type plan, head;
   logic     push, full, pop, nonempty;

   // classify words and plan records
   iba_front #(
      .DIRECT_SLOTS (DIRECT_SLOTS),
      .SINGLE_SLOTS (SINGLE_SLOTS),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .csr_port (csr_port),
      .plan     (plan),
      .push     (push),
      .full     (full)
   );

   // buffer plans
   iba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .plan_in  (plan),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .nonempty (nonempty)
   );

   // send records
   iba_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .nonempty (nonempty),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

### verif/inode_block_map_allocator_tb.sv
// Self-checking testbench for the inode block map allocator.
`default_nettype none

module inode_block_map_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iba_pkg::*;

   localparam int DIRECT_SLOTS = 10;
   localparam int SINGLE_SLOTS = 4;
   localparam int BLOCK_BYTES  = 512;
   localparam int MAX_BLOCKS   = 16384;
   localparam int ENTRIES      = BLOCK_BYTES / 4;
   localparam int BYTES_CAP    = 32'h00FF_FFFF;

   typedef enum int {
      LVL_DIRECT,
      LVL_SINGLE,
      LVL_DOUBLE,
      LVL_TRIPLE,
      LVL_FULL
   } map_depth_type;

   typedef struct {
      kind_type                kind;
      logic [HOLDER_W-1:0]     holder;
      logic [SLOT_W-1:0]       slot;
      logic [BLOCK_OUT_W-1:0]  blk;
      logic [BYTES_W-1:0]      bytes;
      logic                    oos;
      logic                    last;
   } map_record_type;

   logic clock;
   logic reset;

   iba_req_if req_if();
   iba_rsp_if rsp_if();
   iba_csr_if csr_if();

   inode_block_map_allocator #(
      .DIRECT_SLOTS(DIRECT_SLOTS),
      .SINGLE_SLOTS(SINGLE_SLOTS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_port(csr_if)
   );

   // register shadow and allocator state of the predictor
   int unsigned   cfg_total;
   int unsigned   cfg_reserved;
   int unsigned   alloc_cursor;
   map_depth_type depth;
   int unsigned   direct_used;
   int unsigned   single_used;
   int unsigned   entries_used [3];
   int unsigned   open_ptr [3];
   int unsigned   file_bytes;

   map_record_type staged[$];
   map_record_type records_due[$];

   int  mismatches;
   bit  idling;
   int  hold_request;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit needs_fresh(int unsigned used);
      return used == 0 || used >= ENTRIES;
   endfunction

   function automatic int unsigned free_base();
      return alloc_cursor > cfg_reserved ? alloc_cursor : cfg_reserved;
   endfunction

   function automatic void clear_file_layout();
      depth        = LVL_DIRECT;
      direct_used  = 0;
      single_used  = 0;
      entries_used = '{0, 0, 0};
      open_ptr     = '{0, 0, 0};
      file_bytes   = 0;
   endfunction

   function automatic void stage(kind_type kind, int unsigned holder, int unsigned slot,
                                 int unsigned blk, bit oos);
      map_record_type r;
      r.kind   = kind;
      r.holder = holder[HOLDER_W-1:0];
      r.slot   = slot[SLOT_W-1:0];
      r.blk    = blk[BLOCK_OUT_W-1:0];
      r.bytes  = '0;
      r.oos    = oos;
      r.last   = 1'b0;
      staged.push_back(r);
   endfunction

   // Work out the records one accepted data block causes.
   function automatic void plan_placement(bit last_blk);
      bit          fresh_inner;
      bit          fresh_mid;
      bit          fresh_top;
      int unsigned need;
      int unsigned limit;
      int unsigned base;
      int unsigned blk;
      fresh_inner = 1'b0;
      fresh_mid   = 1'b0;
      fresh_top   = 1'b0;
      need        = 0;

      // step down the map while the current level is used up
      if (depth == LVL_DIRECT && direct_used >= DIRECT_SLOTS) begin
         depth = LVL_SINGLE;
         entries_used = '{0, 0, 0};
      end
      if (depth == LVL_SINGLE && needs_fresh(entries_used[0]) &&
          single_used >= SINGLE_SLOTS) begin
         depth = LVL_DOUBLE;
         entries_used = '{0, 0, 0};
      end
      if (depth == LVL_DOUBLE && needs_fresh(entries_used[0]) &&
          entries_used[1] >= ENTRIES) begin
         depth = LVL_TRIPLE;
         entries_used = '{0, 0, 0};
      end
      if (depth == LVL_TRIPLE && needs_fresh(entries_used[0]) &&
          needs_fresh(entries_used[1]) && entries_used[2] >= ENTRIES)
         depth = LVL_FULL;

      // count pointer blocks plus the data block
      case (depth)
         LVL_DIRECT: need = 1;
         LVL_SINGLE: begin
            fresh_inner = needs_fresh(entries_used[0]);
            need = 1 + fresh_inner;
         end
         LVL_DOUBLE: begin
            fresh_inner = needs_fresh(entries_used[0]);
            fresh_mid   = entries_used[1] == 0;
            need = 1 + fresh_inner + fresh_mid;
         end
         LVL_TRIPLE: begin
            fresh_inner = needs_fresh(entries_used[0]);
            fresh_mid   = fresh_inner && needs_fresh(entries_used[1]);
            fresh_top   = fresh_mid && entries_used[2] == 0;
            need = 1 + fresh_inner + fresh_mid + fresh_top;
         end
         default: ;
      endcase

      limit = cfg_total < MAX_BLOCKS ? cfg_total : MAX_BLOCKS;
      base  = free_base();

      if (depth == LVL_FULL || base + need > limit) begin
         // drop the data, report no space
         stage(KIND_DATA, 0, 0, 0, 1'b1);
      end else begin
         blk = base;
         if (depth == LVL_DIRECT) begin
            stage(KIND_DIRECT, 0, direct_used, blk, 1'b0);
            direct_used++;
         end else begin
            if (fresh_top) begin
               stage(KIND_TRIPLE, 0, 0, blk, 1'b0);
               open_ptr[2] = blk;
               blk++;
            end
            if (fresh_mid) begin
               if (depth == LVL_TRIPLE) begin
                  stage(KIND_ENTRY, open_ptr[2], entries_used[2], blk, 1'b0);
                  entries_used[2]++;
               end else begin
                  stage(KIND_DOUBLE, 0, 0, blk, 1'b0);
               end
               open_ptr[1] = blk;
               blk++;
               entries_used[1] = 0;
            end
            if (fresh_inner) begin
               if (depth == LVL_SINGLE) begin
                  stage(KIND_SINGLE, 0, single_used, blk, 1'b0);
                  single_used++;
               end else begin
                  stage(KIND_ENTRY, open_ptr[1], entries_used[1], blk, 1'b0);
                  entries_used[1]++;
               end
               open_ptr[0] = blk;
               blk++;
               entries_used[0] = 0;
            end
            stage(KIND_ENTRY, open_ptr[0], entries_used[0], blk, 1'b0);
            entries_used[0]++;
         end
         stage(KIND_DATA, 0, 0, blk, 1'b0);
         alloc_cursor = blk + 1;
         file_bytes = (file_bytes + BLOCK_BYTES > BYTES_CAP) ? BYTES_CAP
                                                             : file_bytes + BLOCK_BYTES;
      end

      if (last_blk)
         stage(KIND_DONE, 0, 0, 0, 1'b0);

      // stamp byte count on every record, flag the final one
      foreach (staged[i]) begin
         staged[i].bytes = file_bytes[BYTES_W-1:0];
         staged[i].last  = (i == staged.size() - 1);
         records_due.push_back(staged[i]);
      end
      staged.delete();

      if (last_blk)
         clear_file_layout();
   endfunction

   // ---------------------------------------------------------------- drivers

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one data block and wait for its handshake.
   task automatic send_block(input bit last_blk);
      int gap;
      gap = idling ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid      <= 1'b0;
         req_if.last_block <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.last_block <= last_blk;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      plan_placement(last_blk);
   endtask

   // Send a whole file of the given length.
   task automatic send_file(input int unsigned blocks);
      for (int unsigned j = 1; j <= blocks; j++)
         send_block(j == blocks);
   endtask

   // Drop the input and wait until every record is back.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      if (idx == CSR_IMAGE_BLOCKS)
         cfg_total = value & 32'h7FFF;
      else if (idx == CSR_RESERVED_BLOCKS)
         cfg_reserved = value & 32'h3FFF;
      @(posedge clock);
   endtask

   // Drive rsp ready: random stalls, or a long hold when a test asks for one.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && idling && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checker

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted record with the oldest one due.
   always @(posedge clock) begin
      map_record_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (records_due.size() == 0) begin
            $display("%0t ns: record with none due, expected nothing, actual kind %0d blk %0d",
                     $time, rsp_if.record_kind, rsp_if.block_number);
            mismatches++;
         end else begin
            want = records_due.pop_front();
            check_field("record_kind", 32'(want.kind), 32'(rsp_if.record_kind));
            check_field("holder_block", 32'(want.holder), 32'(rsp_if.holder_block));
            check_field("slot_index", 32'(want.slot), 32'(rsp_if.slot_index));
            check_field("block_number", 32'(want.blk), 32'(rsp_if.block_number));
            check_field("byte_total", 32'(want.bytes), 32'(rsp_if.byte_total));
            check_field("out_of_space", 32'(want.oos), 32'(rsp_if.out_of_space));
            check_field("last", 32'(want.last), 32'(rsp_if.last));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // One-block image: block 0 fits, the rest runs out, done still follows.
   task automatic test_tiny_image();
      write_csr(CSR_IMAGE_BLOCKS, 1);
      write_csr(CSR_RESERVED_BLOCKS, 0);
      send_block(1'b0);
      send_block(1'b0);
      send_block(1'b1);
      wait_for_drain();
      write_csr(CSR_IMAGE_BLOCKS, 32767);
   endtask

   // Fill the direct slots, then squeeze the limit around the first single pointer.
   task automatic test_space_boundary();
      for (int j = 0; j < DIRECT_SLOTS; j++)
         send_block(1'b0);
      wait_for_drain();
      // pointer plus data need two blocks: one is not enough
      write_csr(CSR_IMAGE_BLOCKS, free_base() + 1);
      send_block(1'b0);
      wait_for_drain();
      // exact fit, then nothing left for the remaining blocks
      write_csr(CSR_IMAGE_BLOCKS, free_base() + 2);
      send_block(1'b0);
      send_block(1'b0);
      send_block(1'b1);
      wait_for_drain();
      write_csr(CSR_IMAGE_BLOCKS, MAX_BLOCKS);
   endtask

   // Raise the reserved area past the cursor, then lower it below again.
   task automatic test_reserved_jump();
      write_csr(CSR_RESERVED_BLOCKS, alloc_cursor + 100);
      send_file(1);
      send_file(2);
      wait_for_drain();
      write_csr(CSR_RESERVED_BLOCKS, 0);
      send_file(2);
      wait_for_drain();
   endtask

   // Hold the result side while blocks keep coming so the input stalls.
   task automatic test_backpressure();
      idling = 1'b0;
      hold_request = 80;
      send_file(12);
      wait_for_drain();
      idling = 1'b1;
   endtask

   // One long file that fills the direct slots and runs on into a single pointer.
   task automatic test_deep_file();
      send_file(DIRECT_SLOTS + 24);
      wait_for_drain();
   endtask

   // Random file lengths, about n_items blocks in all.
   task automatic random_files(input int n_items);
      int sent;
      int r;
      int len;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 9);
         if (r < 6)
            len = $urandom_range(1, 9);
         else if (r < 9)
            len = $urandom_range(10, 20);
         else
            len = $urandom_range(21, 40);
         send_file(len);
         sent += len;
      end
   endtask

   task automatic test_random_files();
      random_files(10);
      wait_for_drain();
      // tight image, no idling: space may run out partway through
      write_csr(CSR_IMAGE_BLOCKS, free_base() + $urandom_range(15, 40));
      idling = 1'b0;
      random_files(10);
      wait_for_drain();
      idling = 1'b1;
      write_csr(CSR_IMAGE_BLOCKS, MAX_BLOCKS);
      write_csr(CSR_RESERVED_BLOCKS, alloc_cursor + $urandom_range(1, 200));
      random_files(10);
      wait_for_drain();
   endtask

   // Reserve all but the top block: one fits, then the image is full.
   task automatic test_end_of_image();
      write_csr(CSR_IMAGE_BLOCKS, 32767);
      write_csr(CSR_RESERVED_BLOCKS, 16383);
      send_block(1'b0);
      send_block(1'b0);
      send_block(1'b1);
      send_file(3);
      wait_for_drain();
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      mismatches   = 0;
      idling       = 1'b1;
      hold_request = 0;
      cfg_total    = MAX_BLOCKS;
      cfg_reserved = 0;
      alloc_cursor = 0;
      clear_file_layout();

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.last_block <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= CSR_IMAGE_BLOCKS;
      csr_if.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_tiny_image();
      test_space_boundary();
      test_reserved_jump();
      test_backpressure();
      test_deep_file();
      test_random_files();
      test_end_of_image();

      if (mismatches == 0 && records_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
